FILE: rtl/pstc_pkg.sv
// ----------------------------------------------------------------------------
// pstc_pkg
// Shared types, constants and helper functions for the spectrum color pipeline.
// ----------------------------------------------------------------------------
package pstc_pkg;

  localparam int PIXEL_BITS = 16;
  localparam int FS_BITS    = 16;
  localparam int W_BITS     = 17;   // wavelength offset, Q.8 nm
  localparam int Q_BITS     = 17;   // unsigned Q1.16 fraction, up to 1.0

  // Wavelength breakpoints as offsets from 380 nm, Q.8
  localparam logic [W_BITS-1:0] W_SPAN = 17'd102400;
  localparam logic [W_BITS-1:0] W_420  = 17'd10240;
  localparam logic [W_BITS-1:0] W_440  = 17'd15360;
  localparam logic [W_BITS-1:0] W_490  = 17'd28160;
  localparam logic [W_BITS-1:0] W_510  = 17'd33280;
  localparam logic [W_BITS-1:0] W_580  = 17'd51200;
  localparam logic [W_BITS-1:0] W_645  = 17'd67840;
  localparam logic [W_BITS-1:0] W_700  = 17'd81920;
  localparam logic [Q_BITS-1:0] Q_ONE  = 17'd65536;

  // pixel * 400 nm * 256, before the shift by 8
  localparam logic [8:0] SPAN_NM = 9'd400;
  localparam int PROD_BITS = PIXEL_BITS + 9;

  // Pipelined long division: 4 quotient bits per stage, 5 stages
  localparam int DIV_STEPS  = 4;
  localparam int DIV_STAGES = 5;
  localparam int QUO_BITS   = DIV_STEPS * DIV_STAGES;

  // Constant division by reciprocal multiply
  localparam int A_BITS      = 23;
  localparam int M_BITS      = 21;
  localparam int RECIP_SHIFT = 23;
  localparam int unsigned RECIP_ONE = 32'd1 << RECIP_SHIFT;
  localparam logic [M_BITS-1:0] RECIP_5  = M_BITS'(RECIP_ONE / 5);
  localparam logic [M_BITS-1:0] RECIP_15 = M_BITS'(RECIP_ONE / 15);
  localparam logic [M_BITS-1:0] RECIP_25 = M_BITS'(RECIP_ONE / 25);
  localparam logic [M_BITS-1:0] RECIP_35 = M_BITS'(RECIP_ONE / 35);
  localparam logic [M_BITS-1:0] RECIP_65 = M_BITS'(RECIP_ONE / 65);

  // Pipeline stage map
  localparam int N_STAGES = 12;
  localparam int ST_SEG   = DIV_STAGES + 1;
  localparam int ST_CDIV  = ST_SEG + 1;
  localparam int ST_SCALE = ST_CDIV + 3;

  typedef enum logic [2:0] {
    DIV_5,
    DIV_15,
    DIV_25,
    DIV_35,
    DIV_65
  } divisor_t;

  typedef enum logic [1:0] {
    TERM_ZERO,
    TERM_ONE,
    TERM_DIV
  } term_kind_t;

  typedef struct packed {
    term_kind_t        kind;
    divisor_t          dsel;
    logic [A_BITS-1:0] dividend;
  } term_t;

  typedef struct packed {
    logic                sat;
    logic [FS_BITS-1:0]  rem;
    logic [QUO_BITS-1:0] num;
    logic [QUO_BITS-1:0] quo;
  } div_state_t;

  function automatic logic [6:0] divisor_value(divisor_t dsel);
    logic [6:0] val;
    unique case (dsel)
      DIV_5:   val = 7'd5;
      DIV_15:  val = 7'd15;
      DIV_25:  val = 7'd25;
      DIV_35:  val = 7'd35;
      DIV_65:  val = 7'd65;
      default: val = 7'd5;
    endcase
    return val;
  endfunction

  function automatic logic [M_BITS-1:0] divisor_recip(divisor_t dsel);
    logic [M_BITS-1:0] val;
    unique case (dsel)
      DIV_5:   val = RECIP_5;
      DIV_15:  val = RECIP_15;
      DIV_25:  val = RECIP_25;
      DIV_35:  val = RECIP_35;
      DIV_65:  val = RECIP_65;
      default: val = RECIP_5;
    endcase
    return val;
  endfunction

endpackage

FILE: rtl/pstc_div_stage.sv
// ----------------------------------------------------------------------------
// pstc_div_stage
// One registered slice of the restoring divider: four quotient bits per stage.
// ----------------------------------------------------------------------------
module pstc_div_stage import pstc_pkg::*; (
  input  logic               clk,
  input  logic               en,
  input  logic [FS_BITS-1:0] fs,
  input  div_state_t         d,
  output div_state_t         q
);

  div_state_t      q_next;
  logic [FS_BITS:0] trial;

  always_comb begin
    q_next = d;
    trial  = '0;
    for (int i = 0; i < DIV_STEPS; i++) begin
      trial      = {q_next.rem, q_next.num[QUO_BITS-1]};
      q_next.num = {q_next.num[QUO_BITS-2:0], 1'b0};
      if (trial >= {1'b0, fs}) begin
        q_next.rem = FS_BITS'(trial - {1'b0, fs});
        q_next.quo = {q_next.quo[QUO_BITS-2:0], 1'b1};
      end else begin
        q_next.rem = trial[FS_BITS-1:0];
        q_next.quo = {q_next.quo[QUO_BITS-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q <= q_next;
    end
  end

endmodule

FILE: rtl/pstc_segment.sv
// ----------------------------------------------------------------------------
// pstc_segment
// Picks the spectrum segment and forms the dividend of each color fraction
// and of the intensity factor.
// ----------------------------------------------------------------------------
module pstc_segment import pstc_pkg::*; (
  input  logic              clk,
  input  logic              en,
  input  logic              sat,
  input  logic [W_BITS-1:0] quo,
  output term_t             red_term,
  output term_t             green_term,
  output term_t             blue_term,
  output term_t             factor_term
);

  localparam term_t T_ZERO = '{kind: TERM_ZERO, dsel: DIV_5, dividend: '0};
  localparam term_t T_ONE  = '{kind: TERM_ONE,  dsel: DIV_5, dividend: '0};

  logic [W_BITS-1:0] w;
  logic [W_BITS:0]   hi_sum;
  logic [W_BITS-1:0] lo_sum;
  term_t             r_next, g_next, b_next, s_next;

  assign w = sat ? W_SPAN : quo;

  // 0.3 + 0.7 * distance, scaled so the divisor reduces to 25
  assign hi_sum = 18'd61440 + 18'(W_SPAN - w) * 18'd7;
  assign lo_sum = 17'd30720 + w * 17'd7;

  always_comb begin
    r_next = T_ONE;
    g_next = T_ZERO;
    b_next = T_ZERO;
    priority if (w < W_440) begin
      r_next = '{kind: TERM_DIV, dsel: DIV_15, dividend: A_BITS'(W_440 - w) << 6};
      b_next = T_ONE;
    end else if (w < W_490) begin
      r_next = T_ZERO;
      g_next = '{kind: TERM_DIV, dsel: DIV_25, dividend: A_BITS'(w - W_440) << 7};
      b_next = T_ONE;
    end else if (w < W_510) begin
      r_next = T_ZERO;
      g_next = T_ONE;
      b_next = '{kind: TERM_DIV, dsel: DIV_5, dividend: A_BITS'(W_510 - w) << 6};
    end else if (w < W_580) begin
      r_next = '{kind: TERM_DIV, dsel: DIV_35, dividend: A_BITS'(w - W_510) << 7};
      g_next = T_ONE;
    end else if (w < W_645) begin
      g_next = '{kind: TERM_DIV, dsel: DIV_65, dividend: A_BITS'(W_645 - w) << 8};
    end else begin
      r_next = T_ONE;
    end

    priority if (w > W_700) begin
      s_next = '{kind: TERM_DIV, dsel: DIV_25, dividend: A_BITS'(hi_sum) << 3};
    end else if (w < W_420) begin
      s_next = '{kind: TERM_DIV, dsel: DIV_25, dividend: A_BITS'(lo_sum) << 4};
    end else begin
      s_next = T_ONE;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      red_term    <= r_next;
      green_term  <= g_next;
      blue_term   <= b_next;
      factor_term <= s_next;
    end
  end

endmodule

FILE: rtl/pstc_const_div.sv
// ----------------------------------------------------------------------------
// pstc_const_div
// Three-stage division by a small constant: reciprocal multiply, back
// multiply, one-step remainder correction.
// ----------------------------------------------------------------------------
module pstc_const_div import pstc_pkg::*; (
  input  logic              clk,
  input  logic [2:0]        en,
  input  term_t             t,
  output logic [Q_BITS-1:0] result
);

  localparam int P_BITS  = A_BITS + M_BITS;
  localparam int QD_BITS = Q_BITS + 7;

  term_t               a_term;
  logic [P_BITS-1:0]   a_prod;
  term_t               b_term;
  logic [Q_BITS-1:0]   b_q0;
  logic [QD_BITS-1:0]  b_qd;
  logic [Q_BITS-1:0]   q0;
  logic [QD_BITS-1:0]  rem;
  logic [Q_BITS-1:0]   result_next;

  assign q0  = a_prod[RECIP_SHIFT+Q_BITS-1:RECIP_SHIFT];
  assign rem = QD_BITS'(b_term.dividend) - b_qd;

  always_comb begin
    unique case (b_term.kind)
      TERM_ZERO: result_next = '0;
      TERM_ONE:  result_next = Q_ONE;
      TERM_DIV:  begin
        // estimate is low by at most one
        if (rem >= QD_BITS'(divisor_value(b_term.dsel))) begin
          result_next = b_q0 + Q_BITS'(1);
        end else begin
          result_next = b_q0;
        end
      end
      default:   result_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      a_term <= t;
      a_prod <= P_BITS'(t.dividend) * P_BITS'(divisor_recip(t.dsel));
    end
    if (en[1]) begin
      b_term <= a_term;
      b_q0   <= q0;
      b_qd   <= QD_BITS'(q0) * QD_BITS'(divisor_value(a_term.dsel));
    end
    if (en[2]) begin
      result <= result_next;
    end
  end

endmodule

FILE: rtl/pstc_scale.sv
// ----------------------------------------------------------------------------
// pstc_scale
// Two-stage scaling of a fraction by the intensity factor to an 8-bit level.
// ----------------------------------------------------------------------------
module pstc_scale import pstc_pkg::*; (
  input  logic              clk,
  input  logic [1:0]        en,
  input  logic [Q_BITS-1:0] factor,
  input  logic [Q_BITS-1:0] frac,
  output logic [7:0]        level
);

  localparam int P_BITS = 2 * Q_BITS;

  logic [P_BITS-1:0]   prod;
  logic [P_BITS+7:0]   prod_255;

  // 255 * x as (x << 8) - x
  assign prod_255 = {prod, 8'b0} - (P_BITS+8)'(prod);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      prod <= P_BITS'(factor) * P_BITS'(frac);
    end
    if (en[1]) begin
      level <= prod_255[39:32];
    end
  end

endmodule

FILE: rtl/pixel_to_spectrum_color.sv
// ----------------------------------------------------------------------------
// pixel_to_spectrum_color
// Stages: input register, divider, segment select, constant division, scaling.
// Throughput: one pixel per cycle unless stalled; the 5-stage wavelength
//   divider is the largest part of the depth; a stall holds only full stages.
// Reset: clears all stage valid bits and loads full_scale with 65535.
// Maps a pixel to the RGB color of a visible wavelength (380..780 nm).
// ----------------------------------------------------------------------------
module pixel_to_spectrum_color import pstc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  full_scale_we,
  input  logic [FS_BITS-1:0]    full_scale_wdata,
  input  logic                  pixel_valid,
  output logic                  pixel_ready,
  input  logic [PIXEL_BITS-1:0] pixel_value,
  output logic                  color_valid,
  input  logic                  color_ready,
  output logic [7:0]            red,
  output logic [7:0]            green,
  output logic [7:0]            blue
);

  logic [FS_BITS-1:0]   full_scale;
  logic [FS_BITS-1:0]   fs_eff;
  logic [N_STAGES-1:0]  v;
  logic [N_STAGES-1:0]  en;
  logic [PROD_BITS-1:0] pix_prod;
  div_state_t           div_in;
  div_state_t           div_q [DIV_STAGES+1];
  term_t                red_term, green_term, blue_term, factor_term;
  logic [Q_BITS-1:0]    red_frac, green_frac, blue_frac, factor;

  always_ff @(posedge clk) begin
    if (rst) begin
      full_scale <= 16'hFFFF;
    end else if (full_scale_we) begin
      full_scale <= full_scale_wdata;
    end
  end

  assign fs_eff = (full_scale == '0) ? FS_BITS'(1) : full_scale;

  // Stage advances when empty or when the stage after it advances
  always_comb begin
    en[N_STAGES-1] = !v[N_STAGES-1] || color_ready;
    for (int i = N_STAGES-2; i >= 0; i--) begin
      en[i] = !v[i] || en[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      v <= (v & ~en) | ({v[N_STAGES-2:0], pixel_valid} & en);
    end
  end

  assign pixel_ready = en[0];
  assign color_valid = v[N_STAGES-1];

  // Numerator pix * 400 * 256; top bits seed the remainder
  assign pix_prod = PROD_BITS'(pixel_value) * PROD_BITS'(SPAN_NM);

  always_comb begin
    div_in.sat = (pixel_value >= fs_eff);
    div_in.rem = FS_BITS'(pix_prod[PROD_BITS-1:QUO_BITS-8]);
    div_in.num = {pix_prod[QUO_BITS-9:0], 8'b0};
    div_in.quo = '0;
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      div_q[0] <= div_in;
    end
  end

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
    pstc_div_stage u_div (
      .clk (clk),
      .en  (en[k+1]),
      .fs  (fs_eff),
      .d   (div_q[k]),
      .q   (div_q[k+1])
    );
  end

  pstc_segment u_seg (
    .clk         (clk),
    .en          (en[ST_SEG]),
    .sat         (div_q[DIV_STAGES].sat),
    .quo         (div_q[DIV_STAGES].quo[W_BITS-1:0]),
    .red_term    (red_term),
    .green_term  (green_term),
    .blue_term   (blue_term),
    .factor_term (factor_term)
  );

  pstc_const_div u_cdiv_r (
    .clk (clk), .en (en[ST_CDIV+2:ST_CDIV]), .t (red_term), .result (red_frac)
  );
  pstc_const_div u_cdiv_g (
    .clk (clk), .en (en[ST_CDIV+2:ST_CDIV]), .t (green_term), .result (green_frac)
  );
  pstc_const_div u_cdiv_b (
    .clk (clk), .en (en[ST_CDIV+2:ST_CDIV]), .t (blue_term), .result (blue_frac)
  );
  pstc_const_div u_cdiv_s (
    .clk (clk), .en (en[ST_CDIV+2:ST_CDIV]), .t (factor_term), .result (factor)
  );

  pstc_scale u_scale_r (
    .clk (clk), .en (en[ST_SCALE+1:ST_SCALE]), .factor (factor), .frac (red_frac),
    .level (red)
  );
  pstc_scale u_scale_g (
    .clk (clk), .en (en[ST_SCALE+1:ST_SCALE]), .factor (factor), .frac (green_frac),
    .level (green)
  );
  pstc_scale u_scale_b (
    .clk (clk), .en (en[ST_SCALE+1:ST_SCALE]), .factor (factor), .frac (blue_frac),
    .level (blue)
  );

  // An empty output stage must never block input
  a_ready_when_out_empty: assert property (@(posedge clk) disable iff (rst)
    !v[N_STAGES-1] |-> pixel_ready)
    else $error("pixel_ready low with empty output stage");

  // A transfer in with none out adds exactly one item in flight
  a_occupancy_grows: assert property (@(posedge clk) disable iff (rst)
    (pixel_valid && pixel_ready && !(color_valid && color_ready)) |=>
      ($countones(v) == $past($countones(v)) + 1))
    else $error("pipeline occupancy did not grow by one");

  // A transfer out with none in removes exactly one item
  a_occupancy_drops: assert property (@(posedge clk) disable iff (rst)
    (!(pixel_valid && pixel_ready) && color_valid && color_ready) |=>
      ($countones(v) + 1 == $past($countones(v))))
    else $error("pipeline occupancy did not drop by one");

  // Unsaturated quotient stays inside the 400 nm span
  a_quotient_range: assert property (@(posedge clk) disable iff (rst)
    (v[DIV_STAGES] && !div_q[DIV_STAGES].sat) |->
      (div_q[DIV_STAGES].quo < QUO_BITS'(W_SPAN)))
    else $error("wavelength quotient out of range");

endmodule
